[rtl/pctk_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants of the parent candidate top-k block
package pctk_pkg;

	localparam int ID_W   = 8;
	localparam int ETX_W  = 16;
	localparam int RSSI_W = 16;
	localparam int RANK_W = 16;
	localparam int CFG_W  = 16;
	localparam int CFG_IDX_W = 2;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_ROOT_RANK   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOP_INC     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ETX_DIVISOR = 2'd2;

	localparam logic [CFG_W-1:0] ROOT_RANK_RST   = 16'd256;
	localparam logic [CFG_W-1:0] HOP_INC_RST     = 16'd256;
	localparam logic [CFG_W-1:0] ETX_DIVISOR_RST = 16'd128;

	// action codes of an input transaction
	localparam logic ACT_OFFER = 1'b0;
	localparam logic ACT_CLOSE = 1'b1;

	localparam logic [RANK_W-1:0] RANK_INFINITE = 16'hFFFF;
	localparam logic [ETX_W-1:0]  ETX_MAX       = 16'hFFFF;
	localparam logic [RSSI_W-1:0] RSSI_UNKNOWN  = 16'h7FFF;
	localparam int                ETX_SCALE     = 100;

	// numerator of the conversion: 32-bit product times 100 plus half the increment
	localparam int NUM_W     = 39;
	localparam int DIV_STEPS = 16;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam int QDEPTH = 2;

	typedef struct packed {
		logic              is_close;
		logic [ID_W-1:0]   id;
		logic [ETX_W-1:0]  etx;
		logic [RSSI_W-1:0] rssi;
	} cmd_t;

endpackage

[rtl/pctk_front.sv]
`timescale 1ns / 1ps
// front end: accepts transactions, filters offers and converts rank to path etx
module pctk_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic                              action,
	input  logic [pctk_pkg::ID_W-1:0]         neighbor_id,
	input  logic [pctk_pkg::RANK_W-1:0]       nbr_rank,
	input  logic                              usable,
	input  logic                              has_rssi,
	input  logic signed [7:0]                 rssi_in,
	input  logic                              cfg_we,
	input  logic [pctk_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pctk_pkg::CFG_W-1:0]        cfg_data,
	output logic                              q_push,
	input  logic                              q_full,
	output pctk_pkg::cmd_t                    q_data
);
	import pctk_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_CHK,
		ST_DIV,
		ST_PUSH
	} state_t;

	state_t               state_q;
	logic [CFG_W-1:0]     root_q;
	logic [CFG_W-1:0]     hop_q;
	logic [CFG_W-1:0]     div_q;
	cmd_t                 cmd_q;
	logic [RANK_W-1:0]    delta_q;
	logic [31:0]          prod_q;
	logic [NUM_W-1:0]     num_q;
	logic [15:0]          rem_q;
	logic [15:0]          quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;

	logic                 skip;
	logic [RSSI_W-1:0]    rssi_ext;
	logic [16:0]          trial;
	logic                 trial_ge;

	assign skip     = !usable || (nbr_rank == '0) || (nbr_rank == RANK_INFINITE);
	assign rssi_ext = has_rssi ? {{8{rssi_in[7]}}, rssi_in} : RSSI_UNKNOWN;
	assign trial    = {rem_q, quo_q[15]};
	assign trial_ge = trial >= {1'b0, hop_q};

	assign full   = (state_q != ST_IDLE);
	assign q_push = (state_q == ST_PUSH) && !q_full;
	assign q_data = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q <= ROOT_RANK_RST;
			hop_q  <= HOP_INC_RST;
			div_q  <= ETX_DIVISOR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROOT_RANK:   root_q <= cfg_data;
				REG_HOP_INC:     hop_q  <= cfg_data;
				REG_ETX_DIVISOR: div_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cmd_q   <= '0;
			delta_q <= '0;
			prod_q  <= '0;
			num_q   <= '0;
			rem_q   <= '0;
			quo_q   <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (push) begin
						cmd_q.id   <= neighbor_id;
						cmd_q.rssi <= rssi_ext;
						cmd_q.etx  <= '0;
						delta_q    <= nbr_rank - root_q;
						if (action == ACT_CLOSE) begin
							cmd_q.is_close <= 1'b1;
							state_q        <= ST_PUSH;
						end else if (!skip) begin
							cmd_q.is_close <= 1'b0;
							if (nbr_rank <= root_q) begin
								state_q <= ST_PUSH;
							end else if (hop_q == '0) begin
								cmd_q.etx <= ETX_MAX;
								state_q   <= ST_PUSH;
							end else begin
								state_q <= ST_MUL1;
							end
						end
					end
				end
				ST_MUL1: begin
					prod_q  <= {16'd0, delta_q} * {16'd0, div_q};
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					num_q   <= NUM_W'(prod_q) * NUM_W'(ETX_SCALE) + NUM_W'(hop_q >> 1);
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					// quotient of 2^16 or more saturates, else upper part seeds the remainder
					if (num_q[NUM_W-1:16] >= (NUM_W-16)'(hop_q)) begin
						cmd_q.etx <= ETX_MAX;
						state_q   <= ST_PUSH;
					end else begin
						rem_q   <= num_q[31:16];
						quo_q   <= num_q[15:0];
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= trial_ge ? 16'(trial - {1'b0, hop_q}) : trial[15:0];
					quo_q <= {quo_q[14:0], trial_ge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (!q_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// the final quotient bit goes straight into the etx field at the last step
			if (state_q == ST_DIV && cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
				cmd_q.etx <= {quo_q[14:0], trial_ge};
			end
		end
	end

endmodule

[rtl/pctk_cmd_fifo.sv]
`timescale 1ns / 1ps
// short command queue between the front end and the table
module pctk_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  pctk_pkg::cmd_t wdata,
	input  logic           pop,
	output logic           empty,
	output pctk_pkg::cmd_t rdata
);
	import pctk_pkg::*;

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	cmd_t          mem_q [QDEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (cnt_q == CW'(QDEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[rtl/pctk_back.sv]
`timescale 1ns / 1ps
// back end: sorted candidate table, insertion and slot readout
module pctk_back #(
	parameter int SLOTS = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	output logic                          q_pop,
	input  pctk_pkg::cmd_t                q_data,
	output logic                          empty,
	input  logic                          pop,
	output logic [1:0]                    slot_index,
	output logic [pctk_pkg::ID_W-1:0]     out_id,
	output logic [pctk_pkg::ETX_W-1:0]    out_etx,
	output logic signed [pctk_pkg::RSSI_W-1:0] out_rssi,
	output logic [2:0]                    filled,
	output logic                          last
);
	import pctk_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int FW = $clog2(SLOTS + 1);

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	state_t            state_q;
	logic [FW-1:0]     fill_q;
	logic [IW-1:0]     idx_q;
	logic [ID_W-1:0]   id_q   [SLOTS];
	logic [ETX_W-1:0]  etx_q  [SLOTS];
	logic [RSSI_W-1:0] rssi_q [SLOTS];
	logic [ID_W-1:0]   id_n   [SLOTS];
	logic [ETX_W-1:0]  etx_n  [SLOTS];
	logic [RSSI_W-1:0] rssi_n [SLOTS];
	logic [SLOTS-1:0]  better;
	logic [SLOTS-1:0]  place;
	logic              out_valid_q;
	logic              load;
	logic              idx_last;
	logic              idx_used;

	assign q_pop    = (state_q == ST_IDLE) && !q_empty;
	assign empty    = !out_valid_q;
	assign load     = (state_q == ST_EMIT) && (!out_valid_q || pop);
	assign idx_last = (idx_q == IW'(SLOTS - 1));
	assign idx_used = (FW'(idx_q) < fill_q);

	// the table is sorted, so the better flags form a run up to the end
	always_comb begin
		for (int j = 0; j < SLOTS; j++) begin
			better[j] = (FW'(j) < fill_q) &&
				((q_data.etx < etx_q[j]) ||
				 ((q_data.etx == etx_q[j]) && (q_data.id < id_q[j])));
			place[j]  = better[j] || (FW'(j) == fill_q);
		end
		for (int j = 0; j < SLOTS; j++) begin
			id_n[j]   = id_q[j];
			etx_n[j]  = etx_q[j];
			rssi_n[j] = rssi_q[j];
			if (j > 0 && better[j-1]) begin
				id_n[j]   = id_q[j-1];
				etx_n[j]  = etx_q[j-1];
				rssi_n[j] = rssi_q[j-1];
			end else if (place[j]) begin
				id_n[j]   = q_data.id;
				etx_n[j]  = q_data.etx;
				rssi_n[j] = q_data.rssi;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && !q_data.is_close) begin
			for (int j = 0; j < SLOTS; j++) begin
				id_q[j]   <= id_n[j];
				etx_q[j]  <= etx_n[j];
				rssi_q[j] <= rssi_n[j];
			end
		end
		if (load) begin
			slot_index <= 2'(idx_q);
			out_id     <= idx_used ? id_q[idx_q] : '0;
			out_etx    <= idx_used ? etx_q[idx_q] : '0;
			out_rssi   <= idx_used ? rssi_q[idx_q] : '0;
			filled     <= 3'(fill_q);
			last       <= idx_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						if (q_data.is_close) begin
							idx_q   <= '0;
							state_q <= ST_EMIT;
						end else if (fill_q != FW'(SLOTS)) begin
							fill_q <= fill_q + 1'b1;
						end
					end
				end
				ST_EMIT: begin
					if (load) begin
						if (idx_last) begin
							fill_q  <= '0;
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/parent_candidate_top_k_core.sv]
`timescale 1ns / 1ps
// top level of the parent candidate top-k table
//
// input side: a transaction is taken when push is high and full is low.
// action offer brings a neighbor; unusable neighbors and rank 0 or 65535 are
// dropped. otherwise rank is turned into path etx times 100 and inserted into
// a table of SLOTS entries sorted by etx, then by lower id. action close reads
// out every slot, best slot first on the result side, and then empties the table.
// result side: a result waits while empty is low and is taken on pop.
// the front end holds one transaction at a time: an offer needing the divide
// passes two multiply stages, a range check and a 16-step restoring divider;
// one that saturates in the range check skips the divider, a zero etx, a zero
// increment or a close goes straight to the push, and a drop leaves it idle.
// a two-entry command queue sits between the front end and the table, so the
// front end keeps converting while the table streams out a close.
// a close gives SLOTS results, one per cycle while pop keeps up, through a single
// output register, loaded from the table once the close leaves the queue.
// when pop stays low the readout waits and the queue fills, then full rises.
// configuration writes on cfg_we take effect at once and belong in idle time.
// reset empties the table, loads the register defaults and leaves empty high.
module parent_candidate_top_k_core #(
	parameter int SLOTS = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic                              action,
	input  logic [pctk_pkg::ID_W-1:0]         neighbor_id,
	input  logic [pctk_pkg::RANK_W-1:0]       nbr_rank,
	input  logic                              usable,
	input  logic                              has_rssi,
	input  logic signed [7:0]                 rssi_in,
	input  logic                              cfg_we,
	input  logic [pctk_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pctk_pkg::CFG_W-1:0]        cfg_data,
	output logic                              empty,
	input  logic                              pop,
	output logic [1:0]                        slot_index,
	output logic [pctk_pkg::ID_W-1:0]         out_id,
	output logic [pctk_pkg::ETX_W-1:0]        out_etx,
	output logic signed [pctk_pkg::RSSI_W-1:0] out_rssi,
	output logic [2:0]                        filled,
	output logic                              last
);
	import pctk_pkg::*;

	logic fq_push;
	logic fq_full;
	cmd_t fq_wdata;
	logic fq_pop;
	logic fq_empty;
	cmd_t fq_rdata;

	pctk_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.action      (action),
		.neighbor_id (neighbor_id),
		.nbr_rank    (nbr_rank),
		.usable      (usable),
		.has_rssi    (has_rssi),
		.rssi_in     (rssi_in),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.q_push      (fq_push),
		.q_full      (fq_full),
		.q_data      (fq_wdata)
	);

	pctk_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fq_push),
		.full   (fq_full),
		.wdata  (fq_wdata),
		.pop    (fq_pop),
		.empty  (fq_empty),
		.rdata  (fq_rdata)
	);

	pctk_back #(
		.SLOTS (SLOTS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (fq_empty),
		.q_pop      (fq_pop),
		.q_data     (fq_rdata),
		.empty      (empty),
		.pop        (pop),
		.slot_index (slot_index),
		.out_id     (out_id),
		.out_etx    (out_etx),
		.out_rssi   (out_rssi),
		.filled     (filled),
		.last       (last)
	);

endmodule

[rtl/pctk_checker.sv]
`timescale 1ns / 1ps
// port-level checks of the result stream, bound to the top level
module pctk_checker #(
	parameter int SLOTS = 4
) (
	input logic               clk,
	input logic               arst_n,
	input logic               empty,
	input logic               pop,
	input logic [1:0]         slot_index,
	input logic [7:0]         out_id,
	input logic [15:0]        out_etx,
	input logic signed [15:0] out_rssi,
	input logic [2:0]         filled,
	input logic               last
);

	// a waiting result does not change until it is taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_id) && $stable(out_etx) &&
			$stable(out_rssi) && $stable(slot_index) && $stable(last)))
		else $error("result changed while stalled");

	// the final slot of a run carries the last slot index
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && last) |-> (slot_index == 2'(SLOTS - 1)))
		else $error("last flag on wrong slot");

	// inside a run the next slot follows at once with the next index
	a_run_order: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !last) |=>
			(!empty && slot_index == $past(slot_index) + 2'd1 && filled == $past(filled)))
		else $error("slot run broken");

	// an empty table reads out zeroed slots
	a_zero_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(SLOTS < 8 && !empty && filled == 3'd0) |->
			(out_id == 8'd0 && out_etx == 16'd0 && out_rssi == 16'sd0))
		else $error("empty table gave nonzero slot");

endmodule

bind parent_candidate_top_k_core pctk_checker #(.SLOTS(SLOTS)) u_pctk_checker (.*);
